@@ src/price_level_book_update_defines.svh @@
// Assertion macros shared by the price level book RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef PRICE_LEVEL_BOOK_UPDATE_DEFINES_SVH
`define PRICE_LEVEL_BOOK_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PLBU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PLBU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/plbu_pkg.sv @@
// Package for the price level book: operation and side codes, field widths.
// Depends on nothing; used by price_level_book_update.
package plbu_pkg;

   localparam int OP_W    = 3;
   localparam int SIDE_W  = 2;
   localparam int LEVEL_W = 3;
   localparam int FIELD_W = 32;

   typedef enum logic [OP_W-1:0] {
      OP_NEW      = 3'd0,
      OP_CHANGE   = 3'd1,
      OP_DELETE   = 3'd2,
      OP_OVERLAY  = 3'd3,
      OP_SNAPSHOT = 3'd4,
      OP_READ     = 3'd5
   } op_type;

   typedef enum logic [SIDE_W-1:0] {
      SIDE_BID         = 2'd0,
      SIDE_ASK         = 2'd1,
      SIDE_DERIVED_BID = 2'd2,
      SIDE_DERIVED_ASK = 2'd3
   } side_type;

endpackage

@@ src/price_level_book_update.sv @@
// Fixed-depth market-by-price book, top level and only module.
// Depends on plbu_pkg and price_level_book_update_defines.svh.
//
// The block takes one book entry per clock: an item is accepted on every
// rising edge where start is high and busy is low, and busy is never raised,
// so a new item may follow in every cycle. An accepted item is captured in an
// input register; in the next cycle the shift network of the addressed side
// computes the new levels, which are written to the book together with the
// result register. The result appears on the rsp_ ports for exactly one cycle,
// marked by rsp_valid, once the item has passed the input register and the
// result register. The receiver cannot stall the block, so it must take each
// result in the cycle it is shown. Results come out in the order items went in,
// and each item sees the book as left by every item accepted before it.
`include "price_level_book_update_defines.svh"

module price_level_book_update #(
   parameter int BOOK_DEPTH = 5,
   parameter int PRICE_BITS = 32,
   parameter int SIZE_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [1:0]  req_book_side,
   input  logic [2:0]  req_level,
   input  logic signed [31:0] req_price,
   input  logic [31:0] req_quantity,
   input  logic        req_trial_snapshot,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_level_price,
   output logic [31:0] rsp_level_size,
   output logic signed [31:0] rsp_best_bid_price,
   output logic [31:0] rsp_best_bid_size,
   output logic signed [31:0] rsp_best_ask_price,
   output logic [31:0] rsp_best_ask_size,
   output logic        rsp_rejected
);

   // Bits needed to address one level inside the configured depth.
   localparam int LVL_BITS = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;

   // One price level as it is kept in the book.
   typedef struct packed {
      logic [PRICE_BITS-1:0] price;
      logic [SIZE_BITS-1:0]  size;
   } level_type;

   // The book never holds items off.
   assign busy = 1'b0;

   // ---------------------------------------------------------------------
   // Input register. The item is held here while the update
   // of the book is worked out.
   // ---------------------------------------------------------------------
   logic                           req_valid_ff;
   logic [plbu_pkg::OP_W-1:0]      req_op_ff;
   logic [plbu_pkg::SIDE_W-1:0]    req_side_ff;
   logic [plbu_pkg::LEVEL_W-1:0]   req_level_ff;
   logic [plbu_pkg::FIELD_W-1:0]   req_price_ff;
   logic [plbu_pkg::FIELD_W-1:0]   req_quantity_ff;
   logic                           req_trial_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      if (start && !busy) begin
         req_op_ff       <= req_op;
         req_side_ff     <= req_book_side;
         req_level_ff    <= req_level;
         req_price_ff    <= req_price;
         req_quantity_ff <= req_quantity;
         req_trial_ff    <= req_trial_snapshot;
      end
   end

   // ---------------------------------------------------------------------
   // Decode of the registered item.
   // ---------------------------------------------------------------------
   logic [63:0]         price_ext;
   logic [63:0]         size_ext;
   level_type           new_lvl;
   logic                is_derived;
   logic                level_ok;
   logic                snap_write;
   logic [LVL_BITS-1:0] lvl_idx;

   always_comb begin
      // The price is sign-extended and then kept at the book's price width;
      // the size is zero-extended and kept at the book's size width.
      price_ext     = 64'($signed(req_price_ff));
      size_ext      = 64'(req_quantity_ff);
      new_lvl.price = price_ext[PRICE_BITS-1:0];
      new_lvl.size  = size_ext[SIZE_BITS-1:0];
      is_derived    = req_side_ff[1];
      level_ok      = 32'(req_level_ff) < BOOK_DEPTH;
      snap_write    = (req_op_ff == plbu_pkg::OP_SNAPSHOT) && !req_trial_ff;
      lvl_idx       = req_level_ff[LVL_BITS-1:0];
   end

   // ---------------------------------------------------------------------
   // Book state: bid side is row zero, ask side row one.
   // ---------------------------------------------------------------------
   level_type levels_ff [2][BOOK_DEPTH];
   level_type levels_in [2][BOOK_DEPTH];
   level_type derived_ff [2];
   level_type derived_in [2];

   // Every level of both sides works out its own next value in parallel.
   // A level sees its neighbor above for an insert and its neighbor below
   // for a delete; the deepest level takes zero on a delete.
   for (genvar j = 0; j < 2; j++) begin : g_side
      for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_lvl
         level_type prev_lvl;
         level_type next_lvl;
         logic      side_hit;
         logic      at_level;
         logic      past_level;

         if (i == 0) begin : g_top
            assign prev_lvl = '0;
         end else begin : g_mid_top
            assign prev_lvl = levels_ff[j][i-1];
         end

         if (i == BOOK_DEPTH - 1) begin : g_bottom
            assign next_lvl = '0;
         end else begin : g_mid_bottom
            assign next_lvl = levels_ff[j][i+1];
         end

         assign side_hit   = !is_derived && (req_side_ff[0] == 1'(j)) && level_ok;
         assign at_level   = req_level_ff == 3'(i);
         assign past_level = 3'(i) > req_level_ff;

         always_comb begin
            levels_in[j][i] = levels_ff[j][i];
            if (req_valid_ff && side_hit) begin
               case (req_op_ff)
                  plbu_pkg::OP_NEW: begin
                     if (at_level) begin
                        levels_in[j][i] = new_lvl;
                     end else if (past_level) begin
                        levels_in[j][i] = prev_lvl;
                     end
                  end
                  plbu_pkg::OP_CHANGE: begin
                     if (at_level) begin
                        levels_in[j][i].size = new_lvl.size;
                     end
                  end
                  plbu_pkg::OP_DELETE: begin
                     if (at_level || past_level) begin
                        levels_in[j][i] = next_lvl;
                     end
                  end
                  plbu_pkg::OP_SNAPSHOT: begin
                     if (at_level && !req_trial_ff) begin
                        levels_in[j][i] = new_lvl;
                     end
                  end
                  default: begin
                     // Overlay, read and the unused codes leave the side alone.
                  end
               endcase
            end
         end
      end
   end

   // Derived levels change only on an overlay or a non-trial snapshot write.
   for (genvar j = 0; j < 2; j++) begin : g_derived
      always_comb begin
         derived_in[j] = derived_ff[j];
         if (req_valid_ff && is_derived && (req_side_ff[0] == 1'(j)) &&
             ((req_op_ff == plbu_pkg::OP_OVERLAY) || snap_write)) begin
            derived_in[j] = new_lvl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff  <= '{default: '0};
         derived_ff <= '{default: '0};
      end else begin
         levels_ff  <= levels_in;
         derived_ff <= derived_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result, read from the book as it stands after this item.
   // ---------------------------------------------------------------------
   level_type   rsp_lvl;
   logic        rejected;
   logic [63:0] lvl_price_ext;
   logic [63:0] bid_price_ext;
   logic [63:0] ask_price_ext;
   logic [63:0] lvl_size_ext;
   logic [63:0] bid_size_ext;
   logic [63:0] ask_size_ext;

   always_comb begin
      rejected = 1'b0;
      if (is_derived) begin
         rsp_lvl = derived_in[req_side_ff[0]];
      end else if (!level_ok) begin
         // A level outside the depth reports zero and changes nothing.
         rsp_lvl  = '0;
         rejected = 1'b1;
      end else begin
         rsp_lvl = levels_in[req_side_ff[0]][lvl_idx];
      end
      lvl_price_ext = 64'($signed(rsp_lvl.price));
      bid_price_ext = 64'($signed(levels_in[0][0].price));
      ask_price_ext = 64'($signed(levels_in[1][0].price));
      lvl_size_ext  = 64'(rsp_lvl.size);
      bid_size_ext  = 64'(levels_in[0][0].size);
      ask_size_ext  = 64'(levels_in[1][0].size);
   end

   logic        rsp_valid_ff;
   logic [31:0] rsp_level_price_ff;
   logic [31:0] rsp_level_size_ff;
   logic [31:0] rsp_bid_price_ff;
   logic [31:0] rsp_bid_size_ff;
   logic [31:0] rsp_ask_price_ff;
   logic [31:0] rsp_ask_size_ff;
   logic        rsp_rejected_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
      if (req_valid_ff) begin
         rsp_level_price_ff <= lvl_price_ext[31:0];
         rsp_level_size_ff  <= lvl_size_ext[31:0];
         rsp_bid_price_ff   <= bid_price_ext[31:0];
         rsp_bid_size_ff    <= bid_size_ext[31:0];
         rsp_ask_price_ff   <= ask_price_ext[31:0];
         rsp_ask_size_ff    <= ask_size_ext[31:0];
         rsp_rejected_ff    <= rejected;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_level_price    = $signed(rsp_level_price_ff);
   assign rsp_level_size     = rsp_level_size_ff;
   assign rsp_best_bid_price = $signed(rsp_bid_price_ff);
   assign rsp_best_bid_size  = rsp_bid_size_ff;
   assign rsp_best_ask_price = $signed(rsp_ask_price_ff);
   assign rsp_best_ask_size  = rsp_ask_size_ff;
   assign rsp_rejected       = rsp_rejected_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   `PLBU_ASSERT_NOW(a_rsp_follows_item, clock, reset, !$past(reset), rsp_valid_ff == $past(req_valid_ff), "result strobe does not follow the registered item")
   `PLBU_ASSERT_NOW(a_reject_reads_zero, clock, reset, rsp_valid_ff && rsp_rejected_ff, (rsp_level_price_ff == 32'd0) && (rsp_level_size_ff == 32'd0), "rejected item reports a nonzero level")
   `PLBU_ASSERT_NEXT(a_reject_out_of_depth, clock, reset, req_valid_ff && !is_derived && !level_ok, rsp_valid_ff && rsp_rejected_ff, "level outside the depth was not rejected")
   `PLBU_ASSERT_NEXT(a_derived_never_rejected, clock, reset, req_valid_ff && is_derived, rsp_valid_ff && !rsp_rejected_ff, "derived side item was rejected")

endmodule

@@ test/tb_price_level_book_update.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for price_level_book_update: a short table of book entries,
// then random entries, each result checked against a typed quote or the book model here.
// Depends on plbu_pkg and the price_level_book_update RTL.
module tb_price_level_book_update;

   localparam int BOOK_DEPTH     = 5;
   localparam int RANDOM_ENTRIES = 800;
   // Random items in this window go out back to back, with no idle cycles.
   localparam int STEADY_FIRST   = 250;
   localparam int STEADY_LAST    = 450;
   // At this random item the sender stops until the book has answered everything.
   localparam int DRAIN_POINT    = 600;

   // Op codes six and seven have no name in the package; the block treats them as reads.
   localparam logic [plbu_pkg::OP_W-1:0] OP_SPARE_SIX   = 3'd6;
   localparam logic [plbu_pkg::OP_W-1:0] OP_SPARE_SEVEN = 3'd7;

   localparam logic signed [plbu_pkg::FIELD_W-1:0] PRICE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [plbu_pkg::FIELD_W-1:0] PRICE_MIN = 32'sh8000_0000;
   localparam logic [plbu_pkg::FIELD_W-1:0]        SIZE_MAX  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [plbu_pkg::OP_W-1:0]           op;
      logic [plbu_pkg::SIDE_W-1:0]         side;
      logic [plbu_pkg::LEVEL_W-1:0]        level;
      logic signed [plbu_pkg::FIELD_W-1:0] price;
      logic [plbu_pkg::FIELD_W-1:0]        quantity;
      logic                                trial;
   } book_entry_t;

   typedef struct packed {
      logic signed [plbu_pkg::FIELD_W-1:0] level_price;
      logic [plbu_pkg::FIELD_W-1:0]        level_size;
      logic signed [plbu_pkg::FIELD_W-1:0] bid_price;
      logic [plbu_pkg::FIELD_W-1:0]        bid_size;
      logic signed [plbu_pkg::FIELD_W-1:0] ask_price;
      logic [plbu_pkg::FIELD_W-1:0]        ask_size;
      logic                                rejected;
   } book_quote_t;

   typedef struct packed {
      logic signed [plbu_pkg::FIELD_W-1:0] price;
      logic [plbu_pkg::FIELD_W-1:0]        size;
   } price_level_t;

   // One row of the directed table. When typed is set, want is the result read straight
   // off the behavior of the book; otherwise the result comes from the book model below.
   typedef struct packed {
      book_entry_t entry;
      logic        typed;
      book_quote_t want;
   } table_row_t;

   localparam book_quote_t QUIET_BOOK  = '0;
   localparam book_quote_t REJECT_ZERO = '{32'sd0, 32'd0, 32'sd0, 32'd0, 32'sd0, 32'd0, 1'b1};
   // A first insert of the extreme positive price and the largest size into an empty book.
   localparam book_quote_t TOP_BID_MAX = '{PRICE_MAX, SIZE_MAX, PRICE_MAX, SIZE_MAX,
                                           32'sd0, 32'd0, 1'b0};

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [plbu_pkg::OP_W-1:0]           req_op = '0;
   logic [plbu_pkg::SIDE_W-1:0]         req_book_side = '0;
   logic [plbu_pkg::LEVEL_W-1:0]        req_level = '0;
   logic signed [plbu_pkg::FIELD_W-1:0] req_price = '0;
   logic [plbu_pkg::FIELD_W-1:0]        req_quantity = '0;
   logic                                req_trial_snapshot = 1'b0;
   logic                                rsp_valid;
   logic signed [plbu_pkg::FIELD_W-1:0] rsp_level_price;
   logic [plbu_pkg::FIELD_W-1:0]        rsp_level_size;
   logic signed [plbu_pkg::FIELD_W-1:0] rsp_best_bid_price;
   logic [plbu_pkg::FIELD_W-1:0]        rsp_best_bid_size;
   logic signed [plbu_pkg::FIELD_W-1:0] rsp_best_ask_price;
   logic [plbu_pkg::FIELD_W-1:0]        rsp_best_ask_size;
   logic                                rsp_rejected;

   // The book as the block should hold it, updated when each item is accepted.
   price_level_t bid_book [BOOK_DEPTH];
   price_level_t ask_book [BOOK_DEPTH];
   price_level_t implied_bid;
   price_level_t implied_ask;

   // Quotes the block owes, oldest first.
   book_quote_t quote_queue [$];
   table_row_t  stim_table [$];
   int          mismatch_count = 0;
   int          quotes_seen = 0;

   price_level_book_update #(
      .BOOK_DEPTH(BOOK_DEPTH),
      .PRICE_BITS(32),
      .SIZE_BITS(32)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_book_side(req_book_side),
      .req_level(req_level),
      .req_price(req_price),
      .req_quantity(req_quantity),
      .req_trial_snapshot(req_trial_snapshot),
      .rsp_valid(rsp_valid),
      .rsp_level_price(rsp_level_price),
      .rsp_level_size(rsp_level_size),
      .rsp_best_bid_price(rsp_best_bid_price),
      .rsp_best_bid_size(rsp_best_bid_size),
      .rsp_best_ask_price(rsp_best_ask_price),
      .rsp_best_ask_size(rsp_best_ask_size),
      .rsp_rejected(rsp_rejected)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   task automatic check_field(input string name, input logic [plbu_pkg::FIELD_W-1:0] got,
                              input logic [plbu_pkg::FIELD_W-1:0] want);
      if (got !== want) begin
         flag_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                 quotes_seen, name, got, want));
      end
   endtask

   // Applies one book entry to the model and returns the quote the block must produce.
   // Prices and sizes are kept at the full 32 bits, so no narrowing applies.
   function automatic book_quote_t apply_book_entry(input book_entry_t e);
      book_quote_t  q;
      price_level_t fresh;
      price_level_t row [BOOK_DEPTH];
      int           lv;
      q = '0;
      lv = int'(e.level);
      fresh.price = e.price;
      fresh.size = e.quantity;
      if (e.side == plbu_pkg::SIDE_DERIVED_BID || e.side == plbu_pkg::SIDE_DERIVED_ASK) begin
         // The derived levels ignore the level field; only overlay and a real snapshot
         // rewrite them, and the quote always reports the addressed derived level.
         if (e.op == plbu_pkg::OP_OVERLAY || (e.op == plbu_pkg::OP_SNAPSHOT && !e.trial)) begin
            if (e.side == plbu_pkg::SIDE_DERIVED_BID) implied_bid = fresh;
            else implied_ask = fresh;
         end
         if (e.side == plbu_pkg::SIDE_DERIVED_BID) begin
            q.level_price = implied_bid.price;
            q.level_size = implied_bid.size;
         end else begin
            q.level_price = implied_ask.price;
            q.level_size = implied_ask.size;
         end
      end else if (lv >= BOOK_DEPTH) begin
         // A level past the depth changes nothing, whatever the op, and reports zeros.
         q.rejected = 1'b1;
      end else begin
         if (e.side == plbu_pkg::SIDE_BID) row = bid_book;
         else row = ask_book;
         case (e.op)
            plbu_pkg::OP_NEW: begin
               for (int i = BOOK_DEPTH - 1; i > lv; i--) row[i] = row[i - 1];
               row[lv] = fresh;
            end
            plbu_pkg::OP_CHANGE: begin
               row[lv].size = fresh.size;
            end
            plbu_pkg::OP_DELETE: begin
               for (int i = lv; i < BOOK_DEPTH - 1; i++) row[i] = row[i + 1];
               row[BOOK_DEPTH - 1] = '0;
            end
            plbu_pkg::OP_SNAPSHOT: begin
               if (!e.trial) row[lv] = fresh;
            end
            // Overlay on a real side, read and the two spare codes leave the side alone.
            default: begin
            end
         endcase
         if (e.side == plbu_pkg::SIDE_BID) bid_book = row;
         else ask_book = row;
         q.level_price = row[lv].price;
         q.level_size = row[lv].size;
      end
      q.bid_price = bid_book[0].price;
      q.bid_size = bid_book[0].size;
      q.ask_price = ask_book[0].price;
      q.ask_size = ask_book[0].size;
      return q;
   endfunction

   // Presents one item from a falling edge and holds it until a rising edge accepts it.
   // The model is advanced at that edge, so its order matches the order of acceptance.
   // The task returns at the falling edge after acceptance, with start still high, so a
   // following item keeps start up without a glitch.
   task automatic send_entry(input book_entry_t entry, input logic typed,
                             input book_quote_t want, input bit may_idle);
      book_quote_t predicted;
      if (may_idle && $urandom_range(0, 99) < 25) begin
         start = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_op = entry.op;
      req_book_side = entry.side;
      req_level = entry.level;
      req_price = entry.price;
      req_quantity = entry.quantity;
      req_trial_snapshot = entry.trial;
      start = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = apply_book_entry(entry);
      quote_queue.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // Result side: the block shows each quote for one cycle and cannot be held off, so
   // every strobe is taken at the rising edge and compared with the oldest owed quote.
   always @(posedge clock) begin : watch_quotes
      book_quote_t want;
      if (!reset && rsp_valid === 1'b1) begin
         quotes_seen++;
         if (quote_queue.size() == 0) begin
            flag_mismatch($sformatf("result %0d arrived with no item waiting for it",
                                    quotes_seen));
         end else begin
            want = quote_queue.pop_front();
            check_field("level_price", rsp_level_price, want.level_price);
            check_field("level_size", rsp_level_size, want.level_size);
            check_field("best_bid_price", rsp_best_bid_price, want.bid_price);
            check_field("best_bid_size", rsp_best_bid_size, want.bid_size);
            check_field("best_ask_price", rsp_best_ask_price, want.ask_price);
            check_field("best_ask_size", rsp_best_ask_size, want.ask_size);
            check_field("rejected", {31'd0, rsp_rejected}, {31'd0, want.rejected});
         end
      end
   end

   // A run that has not finished by this time limit is reported as NOT OK.
   initial begin
      #2_000_000;
      $display("tb_price_level_book_update NOT OK");
      $finish;
   end

   initial begin : stimulus
      book_entry_t entry;
      int          pick;
      bit          may_idle;

      for (int i = 0; i < BOOK_DEPTH; i++) begin
         bid_book[i] = '0;
         ask_book[i] = '0;
      end
      implied_bid = '0;
      implied_ask = '0;

      // Directed table. Rows after reset read an empty book and are typed in; the rest
      // walk the extremes, the other ops and every special case through the model.
      stim_table.push_back('{'{plbu_pkg::OP_READ, plbu_pkg::SIDE_BID, 3'd0,
                               32'sd0, 32'd0, 1'b0},
                             1'b1, QUIET_BOOK});
      stim_table.push_back('{'{plbu_pkg::OP_READ, plbu_pkg::SIDE_ASK, 3'd4,
                               PRICE_MAX, SIZE_MAX, 1'b1},
                             1'b1, QUIET_BOOK});
      stim_table.push_back('{'{plbu_pkg::OP_READ, plbu_pkg::SIDE_DERIVED_BID, 3'd7,
                               32'sd0, 32'd0, 1'b0},
                             1'b1, QUIET_BOOK});
      stim_table.push_back('{'{plbu_pkg::OP_READ, plbu_pkg::SIDE_BID, 3'd7,
                               32'sd0, 32'd0, 1'b0},
                             1'b1, REJECT_ZERO});
      stim_table.push_back('{'{plbu_pkg::OP_NEW, plbu_pkg::SIDE_BID, 3'd0,
                               PRICE_MAX, SIZE_MAX, 1'b0},
                             1'b1, TOP_BID_MAX});
      // Insert at the top pushes the maximum down a level.
      stim_table.push_back('{'{plbu_pkg::OP_NEW, plbu_pkg::SIDE_BID, 3'd0,
                               PRICE_MIN, 32'd0, 1'b1},
                             1'b0, QUIET_BOOK});
      stim_table.push_back('{'{plbu_pkg::OP_NEW, plbu_pkg::SIDE_BID, 3'd2,
                               32'sd100, 32'd7, 1'b0},
                             1'b0, QUIET_BOOK});
      // Insert at the last level overwrites it; nothing deeper shifts.
      stim_table.push_back('{'{plbu_pkg::OP_NEW, plbu_pkg::SIDE_BID, 3'd4,
                               -32'sd1, 32'h0000_0001, 1'b0},
                             1'b0, QUIET_BOOK});
      stim_table.push_back('{'{plbu_pkg::OP_CHANGE, plbu_pkg::SIDE_BID, 3'd1,
                               32'sd5, 32'h5555_AAAA, 1'b1},
                             1'b0, QUIET_BOOK});
      stim_table.push_back('{'{plbu_pkg::OP_DELETE, plbu_pkg::SIDE_BID, 3'd0,
                               32'sd0, 32'd0, 1'b0},
                             1'b0, QUIET_BOOK});
      // Deleting the last level only clears it.
      stim_table.push_back('{'{plbu_pkg::OP_DELETE, plbu_pkg::SIDE_BID, 3'd4,
                               32'sd0, 32'd0, 1'b0},
                             1'b0, QUIET_BOOK});
      stim_table.push_back('{'{plbu_pkg::OP_NEW, plbu_pkg::SIDE_ASK, 3'd0,
                               -32'sd1, 32'd1, 1'b0},
                             1'b0, QUIET_BOOK});
      stim_table.push_back('{'{plbu_pkg::OP_NEW, plbu_pkg::SIDE_ASK, 3'd3,
                               32'sh1234_5678, 32'hDEAD_BEEF, 1'b0},
                             1'b0, QUIET_BOOK});
      stim_table.push_back('{'{plbu_pkg::OP_SNAPSHOT, plbu_pkg::SIDE_ASK, 3'd4,
                               PRICE_MIN, SIZE_MAX, 1'b0},
                             1'b0, QUIET_BOOK});
      // A trial snapshot is skipped.
      stim_table.push_back('{'{plbu_pkg::OP_SNAPSHOT, plbu_pkg::SIDE_ASK, 3'd0,
                               PRICE_MAX, 32'd9, 1'b1},
                             1'b0, QUIET_BOOK});
      // Overlay on a real side is ignored.
      stim_table.push_back('{'{plbu_pkg::OP_OVERLAY, plbu_pkg::SIDE_BID, 3'd0,
                               32'sd77, 32'd77, 1'b0},
                             1'b0, QUIET_BOOK});
      stim_table.push_back('{'{plbu_pkg::OP_OVERLAY, plbu_pkg::SIDE_DERIVED_BID, 3'd6,
                               PRICE_MIN, SIZE_MAX, 1'b0},
                             1'b0, QUIET_BOOK});
      stim_table.push_back('{'{plbu_pkg::OP_SNAPSHOT, plbu_pkg::SIDE_DERIVED_ASK, 3'd0,
                               PRICE_MAX, 32'd3, 1'b0},
                             1'b0, QUIET_BOOK});
      stim_table.push_back('{'{plbu_pkg::OP_SNAPSHOT, plbu_pkg::SIDE_DERIVED_ASK, 3'd1,
                               32'sd8, 32'd8, 1'b1},
                             1'b0, QUIET_BOOK});
      // New, change and delete do nothing on a derived side.
      stim_table.push_back('{'{plbu_pkg::OP_CHANGE, plbu_pkg::SIDE_DERIVED_BID, 3'd0,
                               32'sd4, 32'd4, 1'b0},
                             1'b0, QUIET_BOOK});
      stim_table.push_back('{'{plbu_pkg::OP_NEW, plbu_pkg::SIDE_DERIVED_ASK, 3'd0,
                               32'sd4, 32'd4, 1'b0},
                             1'b0, QUIET_BOOK});
      stim_table.push_back('{'{OP_SPARE_SIX, plbu_pkg::SIDE_BID, 3'd0,
                               32'sd6, 32'd6, 1'b0},
                             1'b0, QUIET_BOOK});
      stim_table.push_back('{'{OP_SPARE_SEVEN, plbu_pkg::SIDE_ASK, 3'd1,
                               32'sd7, 32'd7, 1'b1},
                             1'b0, QUIET_BOOK});
      // Rejected writes leave the book as it was.
      stim_table.push_back('{'{plbu_pkg::OP_NEW, plbu_pkg::SIDE_ASK, 3'd5,
                               32'sd1, 32'd1, 1'b0},
                             1'b0, QUIET_BOOK});
      stim_table.push_back('{'{plbu_pkg::OP_DELETE, plbu_pkg::SIDE_BID, 3'd6,
                               32'sd0, 32'd0, 1'b0},
                             1'b0, QUIET_BOOK});

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_table[i]) begin
         send_entry(stim_table[i].entry, stim_table[i].typed, stim_table[i].want, 1'b1);
      end

      for (int n = 0; n < RANDOM_ENTRIES; n++) begin
         if (n == DRAIN_POINT) begin
            // Hold the sender off until the block has answered every item.
            start = 1'b0;
            while (quote_queue.size() != 0) @(negedge clock);
         end
         // Mostly inserts, deletes and snapshots on the real sides, so the book fills and
         // empties at random depths; the rest exercises the ignored and rejected cases.
         pick = $urandom_range(0, 99);
         if (pick < 24) entry.op = plbu_pkg::OP_NEW;
         else if (pick < 40) entry.op = plbu_pkg::OP_DELETE;
         else if (pick < 52) entry.op = plbu_pkg::OP_CHANGE;
         else if (pick < 67) entry.op = plbu_pkg::OP_SNAPSHOT;
         else if (pick < 77) entry.op = plbu_pkg::OP_OVERLAY;
         else if (pick < 92) entry.op = plbu_pkg::OP_READ;
         else if (pick < 96) entry.op = OP_SPARE_SIX;
         else entry.op = OP_SPARE_SEVEN;

         pick = $urandom_range(0, 99);
         if (pick < 40) entry.side = plbu_pkg::SIDE_BID;
         else if (pick < 80) entry.side = plbu_pkg::SIDE_ASK;
         else if (pick < 90) entry.side = plbu_pkg::SIDE_DERIVED_BID;
         else entry.side = plbu_pkg::SIDE_DERIVED_ASK;

         if ($urandom_range(0, 99) < 85) entry.level = 3'($urandom_range(0, BOOK_DEPTH - 1));
         else entry.level = 3'($urandom_range(BOOK_DEPTH, 7));

         pick = $urandom_range(0, 99);
         if (pick < 3) entry.price = PRICE_MAX;
         else if (pick < 6) entry.price = PRICE_MIN;
         else if (pick < 8) entry.price = 32'sd0;
         else if (pick < 10) entry.price = -32'sd1;
         else entry.price = $urandom;

         pick = $urandom_range(0, 99);
         if (pick < 5) entry.quantity = 32'd0;
         else if (pick < 10) entry.quantity = SIZE_MAX;
         else entry.quantity = $urandom;

         entry.trial = ($urandom_range(0, 99) < 30);

         may_idle = (n < STEADY_FIRST || n >= STEADY_LAST);
         send_entry(entry, 1'b0, QUIET_BOOK, may_idle);
      end

      start = 1'b0;
      while (quote_queue.size() != 0) @(negedge clock);
      // Keep the clock running after the last result, to catch any stray result.
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb_price_level_book_update OK");
      end else begin
         $display("tb_price_level_book_update NOT OK");
      end
      $finish;
   end

endmodule
